// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/ddpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ddpc_pkg
// Types and constants of the differential drive position controller.
// ----------------------------------------------------------------------------
package ddpc_pkg;

    // Move mode held between items.
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_DRIVE = 2'd1,
        MODE_TURN  = 2'd2
    } t_mode;

    // Request kinds carried in the input tuser.
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_DRIVE = 2'd1,
        REQ_TURN  = 2'd2,
        REQ_STOP  = 2'd3
    } t_req;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DRIVE_GAIN = 2'd0;
    localparam logic [1:0] CFG_TURN_GAIN  = 2'd1;
    localparam logic [1:0] CFG_SETTLE_TOL = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] DRIVE_GAIN_RST = 16'd1671;
    localparam logic [15:0] TURN_GAIN_RST  = 16'd3113;
    localparam logic [9:0]  SETTLE_TOL_RST = 10'd1;

    // Target range, 23-bit signed.
    localparam logic signed [22:0] TARGET_MAX = 23'sd4194303;
    localparam logic signed [22:0] TARGET_MIN = -23'sd4194303 - 23'sd1;

    // Q2.14 gain: fraction bits dropped after the multiply.
    localparam int GAIN_FRAC = 14;

endpackage

// ===== rtl/core/differential_drive_p_controller.sv =====
// ----------------------------------------------------------------------------
// differential_drive_p_controller
// Two-sided proportional position controller with a ramping speed cap.
// ----------------------------------------------------------------------------
// Path: input acceptance, then the input register, then the result register
//   and the output port (one input register, one result register).
// Throughput: one transaction per cycle without output stalls; the control
//   step is one pass of logic, a 25x16 multiplier per side, between the registers.
// Reset: synchronous, active low; clears the move state to idle and settled
//   and loads the gain and tolerance registers with their default values.
module differential_drive_p_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata from bit 0: left_position[23:0], right_position[23:0],
    // distance[22:0], speed_limit[6:0], accel_limit[6:0], 3 zero bits.
    input  logic [87:0] i_s_tdata,
    // tuser: req_type[1:0].
    input  logic [1:0]  i_s_tuser,
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata from bit 0: left_drive[7:0], right_drive[7:0], settled,
    // active_mode[1:0], 5 zero bits.
    output logic [23:0] o_m_tdata
);

    `include "assert_macros.svh"

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [15:0] r_drive_gain;
    logic [15:0] r_turn_gain;
    logic [9:0]  r_settle_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_gain <= ddpc_pkg::DRIVE_GAIN_RST;
            r_turn_gain  <= ddpc_pkg::TURN_GAIN_RST;
            r_settle_tol <= ddpc_pkg::SETTLE_TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ddpc_pkg::CFG_DRIVE_GAIN: r_drive_gain <= i_cfg_wdata;
                ddpc_pkg::CFG_TURN_GAIN:  r_turn_gain  <= i_cfg_wdata;
                ddpc_pkg::CFG_SETTLE_TOL: r_settle_tol <= i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register. The item waits here until the result register can
    // take its result; the controller state is updated at that moment.
    // ------------------------------------------------------------------
    logic                   r_in_valid;
    ddpc_pkg::t_req         r_in_req;
    logic signed [23:0]     r_in_lpos;
    logic signed [23:0]     r_in_rpos;
    logic signed [22:0]     r_in_dist;
    logic [6:0]             r_in_speed;
    logic [6:0]             r_in_accel;

    logic                   r_out_valid;
    logic                   advance;

    // The item in the input register moves on when the result register is
    // empty or its content is being taken in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_req   <= ddpc_pkg::t_req'(i_s_tuser);
            r_in_lpos  <= i_s_tdata[23:0];
            r_in_rpos  <= i_s_tdata[47:24];
            r_in_dist  <= i_s_tdata[70:48];
            r_in_speed <= i_s_tdata[77:71];
            r_in_accel <= i_s_tdata[84:78];
        end
    end

    // ------------------------------------------------------------------
    // Controller state.
    // ------------------------------------------------------------------
    ddpc_pkg::t_mode        r_mode,   n_mode;
    logic signed [22:0]     r_ltgt,   n_ltgt;
    logic signed [22:0]     r_rtgt,   n_rtgt;
    logic signed [23:0]     r_lorg,   n_lorg;
    logic signed [23:0]     r_rorg,   n_rorg;
    logic [6:0]             r_cap,    n_cap;
    logic [6:0]             r_spdlim, n_spdlim;
    logic [6:0]             r_ramp,   n_ramp;
    logic                   r_settled, n_settled;

    // Errors: target minus distance travelled since the origin. The
    // travelled distance needs 25 bits, the error 26.
    logic signed [24:0]     l_rel, r_rel;
    logic signed [25:0]     l_err, r_err;
    logic [24:0]            l_mag, r_mag;
    logic [15:0]            gain;
    logic [7:0]             cap_sum;
    logic [6:0]             cap_new;
    logic [40:0]            l_prod, r_prod;
    logic [26:0]            l_q, r_q;
    logic [6:0]             l_lim, r_lim;
    logic                   settle_now;
    logic signed [7:0]      n_out_left, n_out_right;

    always_comb begin
        l_rel = 25'(r_in_lpos) - 25'(r_lorg);
        r_rel = 25'(r_in_rpos) - 25'(r_rorg);
        l_err = 26'(r_ltgt) - 26'(l_rel);
        r_err = 26'(r_rtgt) - 26'(r_rel);
        // Magnitudes stay below 2^25, so the top bit is dropped safely.
        l_mag = l_err[25] ? 25'(-l_err) : 25'(l_err);
        r_mag = r_err[25] ? 25'(-r_err) : 25'(r_err);

        gain = (r_mode == ddpc_pkg::MODE_DRIVE) ? r_drive_gain : r_turn_gain;

        // Ramp the speed cap by one step, limited by the move's speed limit.
        cap_sum = {1'b0, r_cap} + {1'b0, r_ramp};
        cap_new = (cap_sum > {1'b0, r_spdlim}) ? r_spdlim : cap_sum[6:0];

        l_prod = l_mag * gain;
        r_prod = r_mag * gain;
        l_q    = l_prod[40:ddpc_pkg::GAIN_FRAC];
        r_q    = r_prod[40:ddpc_pkg::GAIN_FRAC];
        l_lim  = (l_q > 27'(cap_new)) ? cap_new : l_q[6:0];
        r_lim  = (r_q > 27'(cap_new)) ? cap_new : r_q[6:0];

        settle_now = (l_mag < 25'(r_settle_tol)) && (r_mag < 25'(r_settle_tol));
    end

    always_comb begin
        n_mode      = r_mode;
        n_ltgt      = r_ltgt;
        n_rtgt      = r_rtgt;
        n_lorg      = r_lorg;
        n_rorg      = r_rorg;
        n_cap       = r_cap;
        n_spdlim    = r_spdlim;
        n_ramp      = r_ramp;
        n_settled   = r_settled;
        n_out_left  = 8'sd0;
        n_out_right = 8'sd0;

        case (r_in_req)
            ddpc_pkg::REQ_DRIVE, ddpc_pkg::REQ_TURN: begin
                // Start a move: new origin, targets and limits, cap from zero.
                n_lorg   = r_in_lpos;
                n_rorg   = r_in_rpos;
                n_ltgt   = r_in_dist;
                n_spdlim = r_in_speed;
                n_ramp   = r_in_accel;
                n_cap    = 7'd0;
                n_settled = 1'b0;
                if (r_in_req == ddpc_pkg::REQ_DRIVE) begin
                    n_rtgt = r_in_dist;
                    n_mode = ddpc_pkg::MODE_DRIVE;
                end else begin
                    // The most negative distance has no negation in range.
                    n_rtgt = (r_in_dist == ddpc_pkg::TARGET_MIN) ? ddpc_pkg::TARGET_MAX
                                                                  : -r_in_dist;
                    n_mode = ddpc_pkg::MODE_TURN;
                end
            end
            ddpc_pkg::REQ_STOP: begin
                n_mode    = ddpc_pkg::MODE_IDLE;
                n_ltgt    = 23'sd0;
                n_rtgt    = 23'sd0;
                n_settled = 1'b1;
            end
            default: begin
                // Control tick.
                if (r_mode == ddpc_pkg::MODE_DRIVE || r_mode == ddpc_pkg::MODE_TURN) begin
                    n_cap = cap_new;
                    if (settle_now) begin
                        n_settled = 1'b1;
                        n_mode    = ddpc_pkg::MODE_IDLE;
                        n_ltgt    = 23'sd0;
                        n_rtgt    = 23'sd0;
                    end else begin
                        n_out_left  = l_err[25] ? -$signed({1'b0, l_lim})
                                                :  $signed({1'b0, l_lim});
                        n_out_right = r_err[25] ? -$signed({1'b0, r_lim})
                                                :  $signed({1'b0, r_lim});
                    end
                end else begin
                    n_mode = ddpc_pkg::MODE_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= ddpc_pkg::MODE_IDLE;
            r_ltgt    <= 23'sd0;
            r_rtgt    <= 23'sd0;
            r_lorg    <= 24'sd0;
            r_rorg    <= 24'sd0;
            r_cap     <= 7'd0;
            r_spdlim  <= 7'd0;
            r_ramp    <= 7'd0;
            r_settled <= 1'b1;
        end else if (advance) begin
            r_mode    <= n_mode;
            r_ltgt    <= n_ltgt;
            r_rtgt    <= n_rtgt;
            r_lorg    <= n_lorg;
            r_rorg    <= n_rorg;
            r_cap     <= n_cap;
            r_spdlim  <= n_spdlim;
            r_ramp    <= n_ramp;
            r_settled <= n_settled;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic signed [7:0]      r_out_left;
    logic signed [7:0]      r_out_right;
    logic                   r_out_settled;
    ddpc_pkg::t_mode        r_out_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_left    <= n_out_left;
            r_out_right   <= n_out_right;
            r_out_settled <= n_settled;
            r_out_mode    <= n_mode;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_mode, r_out_settled, r_out_right, r_out_left};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_settled_means_idle, i_clk, i_rst_n,
                   r_settled == (r_mode == ddpc_pkg::MODE_IDLE))
    `ASSERT_ALWAYS(a_cap_within_limit, i_clk, i_rst_n, r_cap <= r_spdlim)
    `ASSERT_IMPLY(a_settled_drives_zero, i_clk, i_rst_n, r_out_valid && r_out_settled,
                  r_out_left == 8'sd0 && r_out_right == 8'sd0)
    `ASSERT_IMPLY(a_drive_symmetric_range, i_clk, i_rst_n, r_out_valid,
                  r_out_left != -8'sd128 && r_out_right != -8'sd128)

endmodule

// ===== tb/differential_drive_p_controller_tb.sv =====
// ----------------------------------------------------------------------------
// differential_drive_p_controller_tb
// Self-checking testbench for the differential drive position controller.
// A short directed table covers idle ticks, stops, restarts, zero speed and
// ramp limits, instant settling and the saturating turn target. After that,
// random moves run under several gain and tolerance settings: a start command
// followed by ticks whose positions close in on the target. Random noise
// transactions are mixed in. Every result is checked field by field against
// an in-bench model of the controller or a typed expectation from the table.
// ----------------------------------------------------------------------------
module differential_drive_p_controller_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ddpc_pkg::*;

    // Generous bound for the slowest correct run: about 1300 transactions with
    // random stalls on both sides, one long receiver hold-off and a few register
    // updates.
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int MOVE_ITEMS  = 210;
    localparam int N_DIRECTED  = 22;

    localparam logic signed [23:0] POS_MAX = 24'sd8388607;
    localparam logic signed [23:0] POS_MIN = -24'sd8388607 - 24'sd1;

    // One result transaction: the two drive commands and the status fields.
    typedef struct packed {
        logic signed [7:0] l_drv;
        logic signed [7:0] r_drv;
        logic              settled;
        t_mode             mode;
    } drive_res_t;

    // One row of the directed table. When has_exp is set, the expected result
    // is the one typed in the row; otherwise the controller model supplies it.
    typedef struct packed {
        t_req              req;
        logic signed [23:0] lpos;
        logic signed [23:0] rpos;
        logic signed [22:0] move_dist;
        logic [6:0]        spd;
        logic [6:0]        acc;
        logic              has_exp;
        drive_res_t        exp_res;
    } dir_row_t;

    typedef struct packed {
        logic [15:0] drive_gain;
        logic [15:0] turn_gain;
        logic [9:0]  tol;
    } gain_set_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals that drive the block. Every input has a
    // known value from time zero.
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // tdata from bit 0: left_position, right_position, distance, speed_limit,
    // accel_limit, 3 zero bits.
    logic [87:0] s_tdata = '0;
    // tuser: req_type.
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // tdata from bit 0: left_drive, right_drive, settled, active_mode, 5 zero
    // bits.
    logic [23:0] m_tdata;

    always #6 clk = ~clk;

    differential_drive_p_controller dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Controller model: its own copy of the move state and the gain and
    // tolerance registers, advanced once per accepted input transaction.
    // ------------------------------------------------------------------------
    t_mode              ctl_mode = MODE_IDLE;
    logic signed [22:0] tgt_l = '0;
    logic signed [22:0] tgt_r = '0;
    logic signed [23:0] org_l = '0;
    logic signed [23:0] org_r = '0;
    logic [6:0]         cap_q = '0;
    logic [6:0]         spd_lim = '0;
    logic [6:0]         ramp = '0;
    logic               settled_q = 1'b1;
    logic [15:0]        g_drive = DRIVE_GAIN_RST;
    logic [15:0]        g_turn = TURN_GAIN_RST;
    logic [9:0]         tol = SETTLE_TOL_RST;

    drive_res_t expected_drives[$];
    int         n_errors = 0;
    int         n_results = 0;
    int         n_cycles = 0;
    // While set, neither side inserts random gaps or stalls.
    bit         calm = 1'b0;

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Error times the Q2.14 gain, truncated toward zero, then limited to the
    // present velocity cap with the sign of the error kept.
    function automatic logic signed [7:0] side_drive(longint err, logic [15:0] gain,
                                                     logic [6:0] cap);
        longint q;
        q = (mag(err) * longint'(gain)) >>> GAIN_FRAC;
        if (q > longint'(cap))
            q = longint'(cap);
        return (err < 0) ? 8'(-q) : 8'(q);
    endfunction

    function automatic drive_res_t control_step(t_req req, logic signed [23:0] lpos,
                                                logic signed [23:0] rpos,
                                                logic signed [22:0] move_dist,
                                                logic [6:0] spd, logic [6:0] acc);
        drive_res_t  res;
        longint      err_l;
        longint      err_r;
        int unsigned lim;
        logic [15:0] gain;
        res = '0;
        case (req)
            REQ_DRIVE, REQ_TURN: begin
                // A start latches the origin and targets; no control step.
                org_l = lpos;
                org_r = rpos;
                tgt_l = move_dist;
                if (req == REQ_DRIVE)
                    tgt_r = move_dist;
                else
                    tgt_r = (move_dist == TARGET_MIN) ? TARGET_MAX : -move_dist;
                spd_lim = spd;
                ramp = acc;
                cap_q = '0;
                settled_q = 1'b0;
                ctl_mode = (req == REQ_DRIVE) ? MODE_DRIVE : MODE_TURN;
            end
            REQ_STOP: begin
                ctl_mode = MODE_IDLE;
                tgt_l = '0;
                tgt_r = '0;
                settled_q = 1'b1;
            end
            default: begin
                if (ctl_mode == MODE_DRIVE || ctl_mode == MODE_TURN) begin
                    err_l = longint'(tgt_l) - (longint'(lpos) - longint'(org_l));
                    err_r = longint'(tgt_r) - (longint'(rpos) - longint'(org_r));
                    gain = (ctl_mode == MODE_DRIVE) ? g_drive : g_turn;
                    // The cap ramps up before the clamp, never past the limit.
                    lim = int'(cap_q) + int'(ramp);
                    if (lim > int'(spd_lim))
                        lim = int'(spd_lim);
                    cap_q = 7'(lim);
                    if (mag(err_l) < longint'(tol) && mag(err_r) < longint'(tol)) begin
                        settled_q = 1'b1;
                        ctl_mode = MODE_IDLE;
                        tgt_l = '0;
                        tgt_r = '0;
                    end else begin
                        res.l_drv = side_drive(err_l, gain, cap_q);
                        res.r_drv = side_drive(err_r, gain, cap_q);
                    end
                end else begin
                    ctl_mode = MODE_IDLE;
                end
            end
        endcase
        res.settled = settled_q;
        res.mode = ctl_mode;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Input side. The transaction is offered until the block takes it; the
    // model runs at the accepting edge, so expectations keep stream order.
    // tvalid stays high from one transaction to the next unless a random gap
    // is inserted.
    // ------------------------------------------------------------------------
    task automatic push_item(input t_req req, input logic signed [23:0] lpos,
                             input logic signed [23:0] rpos,
                             input logic signed [22:0] move_dist,
                             input logic [6:0] spd, input logic [6:0] acc,
                             input logic has_exp, input drive_res_t exp_res);
        drive_res_t res;
        while (!calm && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, acc, spd, move_dist, rpos, lpos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        res = control_step(req, lpos, rpos, move_dist, spd, acc);
        expected_drives.push_back(has_exp ? exp_res : res);
    endtask

    task automatic push_noise();
        push_item(t_req'($urandom_range(3)), 24'($urandom()), 24'($urandom()),
                  23'($urandom()), 7'($urandom()), 7'($urandom()), 1'b0, '0);
    endtask

    // Lowers tvalid and waits until every expected result has come back. The
    // short pause lets the two pipeline stages empty before a register write.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_drives.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all three registers on consecutive edges, with the block idle.
    task automatic write_gains(input gain_set_t gs);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_DRIVE_GAIN;
        cfg_wdata <= gs.drive_gain;
        @(posedge clk);
        g_drive = gs.drive_gain;
        cfg_addr  <= CFG_TURN_GAIN;
        cfg_wdata <= gs.turn_gain;
        @(posedge clk);
        g_turn = gs.turn_gain;
        cfg_addr  <= CFG_SETTLE_TOL;
        cfg_wdata <= {6'b0, gs.tol};
        @(posedge clk);
        tol = gs.tol;
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [23:0] sat24(longint v);
        if (v > longint'(POS_MAX))
            return POS_MAX;
        if (v < longint'(POS_MIN))
            return POS_MIN;
        return 24'(v);
    endfunction

    // Mostly short moves, some over the full range, some at the extremes.
    function automatic logic signed [22:0] pick_distance();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return 23'(int'($urandom_range(4000)) - 2000);
        if (r < 85)
            return 23'($urandom());
        if (r < 90)
            return TARGET_MAX;
        if (r < 95)
            return TARGET_MIN;
        return 23'(int'($urandom_range(6)) - 3);
    endfunction

    // Moves one side's travel toward its target: a random fraction of the
    // remaining error, an occasional snap onto the target, and a little jitter.
    function automatic longint close_in(longint trav, longint tgt);
        longint rem;
        rem = tgt - trav;
        if (mag(rem) < 8 && $urandom_range(1) == 1)
            trav = tgt;
        else
            trav = trav + rem / longint'($urandom_range(1, 4));
        if ($urandom_range(9) == 0)
            trav = trav + longint'(int'($urandom_range(6)) - 3);
        return trav;
    endfunction

    // Random part: well-formed moves with random content, plus noise. A move
    // ends when it settles, after a random number of ticks, or by a stop or a
    // new start.
    task automatic run_moves(input int n_items);
        int                 sent;
        int                 ticks;
        int                 n_ticks;
        t_req               kind;
        logic signed [23:0] o_l;
        logic signed [23:0] o_r;
        logic signed [22:0] move_dist;
        longint             t_l;
        longint             t_r;
        longint             trav_l;
        longint             trav_r;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 12) begin
                push_noise();
                sent++;
            end else begin
                kind = $urandom_range(1) ? REQ_DRIVE : REQ_TURN;
                if ($urandom_range(3) == 0) begin
                    o_l = 24'($urandom());
                    o_r = 24'($urandom());
                end else begin
                    o_l = 24'(int'($urandom_range(200000)) - 100000);
                    o_r = 24'(int'($urandom_range(200000)) - 100000);
                end
                move_dist = pick_distance();
                t_l = longint'(move_dist);
                if (kind == REQ_DRIVE)
                    t_r = longint'(move_dist);
                else
                    t_r = (move_dist == TARGET_MIN) ? longint'(TARGET_MAX)
                                                    : -longint'(move_dist);
                push_item(kind, o_l, o_r, move_dist, 7'($urandom()), 7'($urandom()), 1'b0,
                          '0);
                sent++;
                trav_l = 0;
                trav_r = 0;
                ticks = 0;
                n_ticks = $urandom_range(3, 40);
                while (sent < n_items && ticks < n_ticks && ctl_mode != MODE_IDLE) begin
                    trav_l = close_in(trav_l, t_l);
                    trav_r = close_in(trav_r, t_r);
                    push_item(REQ_TICK, sat24(longint'(o_l) + trav_l),
                              sat24(longint'(o_r) + trav_r), 23'($urandom()),
                              7'($urandom()), 7'($urandom()), 1'b0, '0);
                    sent++;
                    ticks++;
                end
                if (sent < n_items && ctl_mode != MODE_IDLE && $urandom_range(99) < 15) begin
                    push_item(REQ_STOP, 24'($urandom()), 24'($urandom()), 23'($urandom()),
                              7'($urandom()), 7'($urandom()), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table. Typed expectations appear only where the answer is plain:
    // idle ticks, stops, start commands and settling ticks.
    // ------------------------------------------------------------------------
    dir_row_t directed_rows [N_DIRECTED] = '{
        // Tick and stop while idle, at both ends of the position range.
        '{REQ_TICK,  24'sd0, 24'sd0, 23'sd0, 7'd0, 7'd0, 1'b1,
          '{8'sd0, 8'sd0, 1'b1, MODE_IDLE}},
        '{REQ_TICK,  POS_MAX, POS_MIN, TARGET_MAX, 7'd127, 7'd127, 1'b1,
          '{8'sd0, 8'sd0, 1'b1, MODE_IDLE}},
        '{REQ_STOP,  24'sd0, 24'sd0, 23'sd0, 7'd0, 7'd0, 1'b1,
          '{8'sd0, 8'sd0, 1'b1, MODE_IDLE}},
        // Drive from the extreme positions, overshoot, then land exactly.
        '{REQ_DRIVE, POS_MIN, 24'sd8383607, 23'sd1000, 7'd127, 7'd127, 1'b1,
          '{8'sd0, 8'sd0, 1'b0, MODE_DRIVE}},
        '{REQ_TICK,  POS_MIN, 24'sd8383607, 23'sd0, 7'd0, 7'd0, 1'b0, '0},
        '{REQ_TICK,  -24'sd8386608, 24'sd8381607, 23'sd0, 7'd0, 7'd0, 1'b0, '0},
        '{REQ_TICK,  -24'sd8387608, 24'sd8384607, 23'sd0, 7'd0, 7'd0, 1'b1,
          '{8'sd0, 8'sd0, 1'b1, MODE_IDLE}},
        // Turn with the most negative distance: the right target saturates.
        '{REQ_TURN,  24'sd0, 24'sd0, TARGET_MIN, 7'd127, 7'd5, 1'b1,
          '{8'sd0, 8'sd0, 1'b0, MODE_TURN}},
        '{REQ_TICK,  24'sd0, 24'sd0, 23'sd0, 7'd0, 7'd0, 1'b0, '0},
        '{REQ_TICK,  24'sd0, 24'sd0, 23'sd0, 7'd0, 7'd0, 1'b0, '0},
        // Stop in the middle of a move, then an idle tick.
        '{REQ_STOP,  24'sd123, -24'sd456, 23'sd77, 7'd9, 7'd9, 1'b1,
          '{8'sd0, 8'sd0, 1'b1, MODE_IDLE}},
        '{REQ_TICK,  24'sd0, 24'sd0, 23'sd0, 7'd0, 7'd0, 1'b1,
          '{8'sd0, 8'sd0, 1'b1, MODE_IDLE}},
        // Zero speed limit, then a restart with a zero ramp step.
        '{REQ_DRIVE, 24'sd0, 24'sd0, TARGET_MAX, 7'd0, 7'd127, 1'b1,
          '{8'sd0, 8'sd0, 1'b0, MODE_DRIVE}},
        '{REQ_TICK,  24'sd0, 24'sd0, 23'sd0, 7'd0, 7'd0, 1'b0, '0},
        '{REQ_TURN,  24'sd100, -24'sd100, -23'sd300, 7'd127, 7'd0, 1'b1,
          '{8'sd0, 8'sd0, 1'b0, MODE_TURN}},
        '{REQ_TICK,  24'sd100, -24'sd100, 23'sd0, 7'd0, 7'd0, 1'b0, '0},
        // A zero-length move settles on its first tick.
        '{REQ_DRIVE, 24'sd5, 24'sd5, 23'sd0, 7'd100, 7'd30, 1'b1,
          '{8'sd0, 8'sd0, 1'b0, MODE_DRIVE}},
        '{REQ_TICK,  24'sd5, 24'sd5, 23'sd0, 7'd0, 7'd0, 1'b1,
          '{8'sd0, 8'sd0, 1'b1, MODE_IDLE}},
        // Position swing across the whole range: the error is wider than the
        // position fields and the output pins at the cap.
        '{REQ_TURN,  POS_MIN, POS_MIN, 23'sd5, 7'd127, 7'd127, 1'b1,
          '{8'sd0, 8'sd0, 1'b0, MODE_TURN}},
        '{REQ_TICK,  POS_MAX, POS_MAX, 23'sd0, 7'd0, 7'd0, 1'b0, '0},
        '{REQ_TICK,  -24'sd8388603, POS_MIN, 23'sd0, 7'd0, 7'd0, 1'b0, '0},
        '{REQ_STOP,  POS_MAX, POS_MAX, TARGET_MAX, 7'd127, 7'd127, 1'b1,
          '{8'sd0, 8'sd0, 1'b1, MODE_IDLE}}
    };

    // Register settings for the phases after the reset values: unity and half
    // gains, both extremes, a random set, and back to the reset values.
    gain_set_t gain_plan [5] = '{
        '{16'd16384, 16'd8192, 10'd4},
        '{16'hFFFF, 16'hFFFF, 10'd1023},
        '{16'd0, 16'd0, 10'd0},
        '{16'd1671, 16'd3113, 10'd1},
        '{DRIVE_GAIN_RST, TURN_GAIN_RST, SETTLE_TOL_RST}
    };

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            push_item(directed_rows[i].req, directed_rows[i].lpos, directed_rows[i].rpos,
                      directed_rows[i].move_dist, directed_rows[i].spd, directed_rows[i].acc,
                      directed_rows[i].has_exp, directed_rows[i].exp_res);
        run_moves(MOVE_ITEMS);

        // The fourth setting gets random gains and a small tolerance.
        gain_plan[3] = '{16'($urandom()), 16'($urandom()), 10'($urandom_range(1, 64))};
        foreach (gain_plan[p]) begin
            drain();
            write_gains(gain_plan[p]);
            // The first phase runs without any gaps on either side.
            calm = (p == 0);
            run_moves(MOVE_ITEMS);
        end
        calm = 1'b0;

        // Wait out every outstanding result plus the pipeline depth.
        s_tvalid <= 1'b0;
        while (expected_drives.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("differential_drive_p_controller_tb: PASS");
        else
            $display("differential_drive_p_controller_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side. Each accepted result is compared with the oldest
    // expectation. tready stalls at random, and once, early in the random
    // part, it holds off for a long stretch so that both pipeline stages fill
    // and the block stalls its input while the sender keeps offering.
    // ------------------------------------------------------------------------
    task automatic check_result(input logic [23:0] data);
        drive_res_t got;
        drive_res_t want;
        got.l_drv   = data[7:0];
        got.r_drv   = data[15:8];
        got.settled = data[16];
        got.mode    = t_mode'(data[18:17]);
        if (expected_drives.size() == 0) begin
            $display("%0t: result transaction with nothing expected, data %h", $time, data);
            n_errors++;
        end else begin
            want = expected_drives.pop_front();
            if (got.l_drv !== want.l_drv) begin
                $display("%0t: left_drive expected %0d actual %0d", $time, want.l_drv,
                         got.l_drv);
                n_errors++;
            end
            if (got.r_drv !== want.r_drv) begin
                $display("%0t: right_drive expected %0d actual %0d", $time, want.r_drv,
                         got.r_drv);
                n_errors++;
            end
            if (got.settled !== want.settled) begin
                $display("%0t: settled expected %0d actual %0d", $time, want.settled,
                         got.settled);
                n_errors++;
            end
            if (got.mode !== want.mode) begin
                $display("%0t: active_mode expected %0d actual %0d", $time, want.mode,
                         got.mode);
                n_errors++;
            end
        end
    endtask

    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever begin
            @(posedge clk);
            // Values read here are the ones sampled at this edge.
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
                n_results++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && n_results >= 60) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 9);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("differential_drive_p_controller_tb: FAIL");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ddpc_pkg.sv
rtl/core/differential_drive_p_controller.sv
tb/differential_drive_p_controller_tb.sv
